### design/zero_selector_coeff_encoder_defines.svh
// Assertion macros for the zero-selector coefficient encoder.
// Used by the checker file; no other dependencies.
`ifndef ZERO_SELECTOR_COEFF_ENCODER_DEFINES_SVH
`define ZERO_SELECTOR_COEFF_ENCODER_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define ZSCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds around reset.
`define ZSCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/zsce_pkg.sv
// Shared constants and types for the zero-selector coefficient encoder.
// No dependencies.
`default_nettype none

package zsce_pkg;

   localparam int SELECTOR_BITS_DEFAULT  = 32;
   localparam int SELECTOR_BYTES_DEFAULT = 4;
   localparam int COEF_W                 = 9;
   localparam int BYTE_BITS              = 8;
   localparam int BIT_POS_W              = 3;
   localparam int QUEUE_DEPTH            = 4;

   // One classified coefficient on its way from front to back.
   typedef struct packed {
      logic [BYTE_BITS-1:0] low_byte;
      logic                 overflow;
      logic                 last;
      logic                 cand;
      logic                 sel_bit;
   } entry_type;

endpackage

`default_nettype wire

### design/zsce_front.sv
// Front end: accepts coefficients, detects zero candidates, tracks capacity.
// Depends on zsce_pkg.
`default_nettype none

module zsce_front #(
   parameter int SELECTOR_BITS  = zsce_pkg::SELECTOR_BITS_DEFAULT,
   parameter int SELECTOR_BYTES = zsce_pkg::SELECTOR_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [zsce_pkg::COEF_W-1:0]  req_coefficient,
   input  logic                         req_last_coefficient,
   input  logic                         queue_full,
   output logic                         push,
   output zsce_pkg::entry_type          entry
);

   localparam int STORE_BITS = SELECTOR_BYTES * zsce_pkg::BYTE_BITS;
   localparam int CAP        = (SELECTOR_BITS < STORE_BITS) ? SELECTOR_BITS : STORE_BITS;
   localparam int CW         = $clog2(CAP + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          cand, room;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      cand = (req_coefficient[zsce_pkg::BYTE_BITS-1:0] == '0);
      room = (count_ff < CW'(CAP));

      entry.low_byte = req_coefficient[zsce_pkg::BYTE_BITS-1:0];
      entry.overflow = ovf_ff || (cand && !room);
      entry.last     = req_last_coefficient;
      entry.cand     = cand && room;
      entry.sel_bit  = req_coefficient[zsce_pkg::COEF_W-1];

      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (push) begin
         if (req_last_coefficient) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_ff + CW'(entry.cand);
            ovf_in   = entry.overflow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### design/zsce_queue.sv
// Short queue that decouples the front end from the result side.
// Depends on zsce_pkg.
`default_nettype none

module zsce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  zsce_pkg::entry_type push_data,
   input  logic                pop,
   output zsce_pkg::entry_type pop_data,
   output logic                not_empty,
   output logic                full
);

   localparam int PW = $clog2(zsce_pkg::QUEUE_DEPTH);
   localparam int NW = $clog2(zsce_pkg::QUEUE_DEPTH + 1);

   zsce_pkg::entry_type slot_ff [zsce_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] used_ff, used_in;
   logic          do_push, do_pop;

   assign full      = (used_ff == NW'(zsce_pkg::QUEUE_DEPTH));
   assign not_empty = (used_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(zsce_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(zsce_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      used_in = used_ff + NW'(do_push) - NW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/zsce_back.sv
// Back end: emits low bytes, packs selector bits, flushes selector bytes.
// Depends on zsce_pkg.
`default_nettype none

module zsce_back #(
   parameter int SELECTOR_BYTES = zsce_pkg::SELECTOR_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  zsce_pkg::entry_type            q_data,
   input  logic                           q_valid,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [zsce_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                           rsp_is_selector,
   output logic                           rsp_overflow,
   output logic                           rsp_end_of_code
);

   localparam int AW = (SELECTOR_BYTES > 1) ? $clog2(SELECTOR_BYTES) : 1;
   localparam int FW = $clog2(SELECTOR_BYTES + 1);
   localparam int BW = zsce_pkg::BYTE_BITS;
   localparam int PW = zsce_pkg::BIT_POS_W;

   logic [BW-1:0] sel_mem [SELECTOR_BYTES];
   logic [BW-1:0] rd_ff;
   logic [BW-1:0] asm_ff, asm_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          flushing_ff, flushing_in;
   logic [AW-1:0] fidx_ff, fidx_in;
   logic          fovf_ff;
   logic          valid_ff, valid_in;
   logic [BW-1:0] byte_ff;
   logic          is_sel_ff, ovf_ff, eoc_ff;

   logic          load_en, flush_end, cand_write, byte_done, rd_en, start_flush;
   logic [BW-1:0] asm_set, sel_byte;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [FW-1:0] fidx_ext;

   always_comb begin
      load_en     = !valid_ff || !rsp_stall;
      flush_end   = flushing_ff && (fidx_ff == AW'(SELECTOR_BYTES - 1));
      q_pop       = load_en && !flushing_ff && q_valid;
      start_flush = q_pop && q_data.last;
      cand_write  = q_pop && q_data.cand;
      asm_set     = asm_ff | (BW'(q_data.sel_bit) << pos_ff);
      byte_done   = cand_write && (pos_ff == PW'(BW - 1));
      wr_addr     = fill_ff[AW-1:0];
      rd_en       = load_en && (start_flush || (flushing_ff && !flush_end));
      rd_addr     = flushing_ff ? AW'(fidx_ff + AW'(1)) : '0;

      // complete bytes come from memory, the open byte from the assembly register
      fidx_ext = FW'(fidx_ff);
      if (fidx_ext < fill_ff) begin
         sel_byte = rd_ff;
      end else if (fidx_ext == fill_ff) begin
         sel_byte = asm_ff;
      end else begin
         sel_byte = '0;
      end

      asm_in  = asm_ff;
      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (load_en && flush_end) begin
         asm_in  = '0;
         pos_in  = '0;
         fill_in = '0;
      end else if (cand_write) begin
         pos_in = pos_ff + PW'(1);
         if (byte_done) begin
            asm_in  = '0;
            fill_in = fill_ff + FW'(1);
         end else begin
            asm_in = asm_set;
         end
      end

      flushing_in = flushing_ff;
      fidx_in     = fidx_ff;
      if (load_en) begin
         if (flush_end) begin
            flushing_in = 1'b0;
         end else if (flushing_ff) begin
            fidx_in = fidx_ff + AW'(1);
         end else if (start_flush) begin
            flushing_in = 1'b1;
            fidx_in     = '0;
         end
      end

      valid_in = valid_ff;
      if (load_en) begin
         valid_in = flushing_ff || q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_ff      <= '0;
         pos_ff      <= '0;
         fill_ff     <= '0;
         flushing_ff <= 1'b0;
         fidx_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         asm_ff      <= asm_in;
         pos_ff      <= pos_in;
         fill_ff     <= fill_in;
         flushing_ff <= flushing_in;
         fidx_ff     <= fidx_in;
         valid_ff    <= valid_in;
      end
   end

   // selector byte memory; bypass a byte written in the same cycle it is read
   always_ff @(posedge clock) begin
      if (byte_done) begin
         sel_mem[wr_addr] <= asm_set;
      end
      if (rd_en) begin
         rd_ff <= (byte_done && (wr_addr == rd_addr)) ? asm_set : sel_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (start_flush) begin
         fovf_ff <= q_data.overflow;
      end
      if (load_en) begin
         if (flushing_ff) begin
            byte_ff   <= sel_byte;
            is_sel_ff <= 1'b1;
            ovf_ff    <= fovf_ff;
            eoc_ff    <= flush_end;
         end else begin
            byte_ff   <= q_data.low_byte;
            is_sel_ff <= 1'b0;
            ovf_ff    <= q_data.overflow;
            eoc_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_selector = is_sel_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_end_of_code = eoc_ff;

endmodule

`default_nettype wire

### design/zero_selector_coeff_encoder.sv
// A coefficient accepted into the queue is popped by the back end and its low byte registered for output.
// Throughput: one coefficient per cycle while rsp_stall is low and no flush runs; a coefficient
// marked last is followed on the result side by SELECTOR_BYTES selector bytes drained from the selector memory.
// The four-entry queue takes up coefficients that arrive during that drain until it is full, then req_stall
// rises and the input is held off until the queue has room again.
// Reset (synchronous, active high) clears queue, counters, selector fill and output valid.
`default_nettype none

module zero_selector_coeff_encoder #(
   parameter int SELECTOR_BITS  = zsce_pkg::SELECTOR_BITS_DEFAULT,
   parameter int SELECTOR_BYTES = zsce_pkg::SELECTOR_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [zsce_pkg::COEF_W-1:0]    req_coefficient,
   input  logic                           req_last_coefficient,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [zsce_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                           rsp_is_selector,
   output logic                           rsp_overflow,
   output logic                           rsp_end_of_code
);

   zsce_pkg::entry_type push_entry, pop_entry;
   logic push, pop, not_empty, full;

   zsce_front #(
      .SELECTOR_BITS  (SELECTOR_BITS),
      .SELECTOR_BYTES (SELECTOR_BYTES)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_coefficient      (req_coefficient),
      .req_last_coefficient (req_last_coefficient),
      .queue_full           (full),
      .push                 (push),
      .entry                (push_entry)
   );

   zsce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .not_empty (not_empty),
      .full      (full)
   );

   zsce_back #(
      .SELECTOR_BYTES (SELECTOR_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (pop_entry),
      .q_valid         (not_empty),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_selector (rsp_is_selector),
      .rsp_overflow    (rsp_overflow),
      .rsp_end_of_code (rsp_end_of_code)
   );

endmodule

`default_nettype wire

### design/zsce_checker.sv
// Port-level checker for the zero-selector coefficient encoder, bound to the top level.
// Depends on zsce_pkg and zero_selector_coeff_encoder_defines.svh.
`default_nettype none

`include "zero_selector_coeff_encoder_defines.svh"

module zsce_checker #(
   parameter int SELECTOR_BYTES = zsce_pkg::SELECTOR_BYTES_DEFAULT
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [zsce_pkg::BYTE_BITS-1:0] rsp_out_byte,
   input wire logic                           rsp_is_selector,
   input wire logic                           rsp_overflow,
   input wire logic                           rsp_end_of_code
);

   localparam int FW = $clog2(SELECTOR_BYTES + 1);

   logic          taken;
   logic          seen_ff, seen_in;
   logic          prev_ovf_ff, prev_ovf_in;
   logic [FW-1:0] sel_cnt_ff, sel_cnt_in;

   always_comb begin
      taken       = rsp_valid && !rsp_stall;
      seen_in     = seen_ff || taken;
      prev_ovf_in = taken ? rsp_overflow : prev_ovf_ff;
      sel_cnt_in  = sel_cnt_ff;
      if (taken && rsp_is_selector) begin
         sel_cnt_in = rsp_end_of_code ? '0 : sel_cnt_ff + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         prev_ovf_ff <= 1'b0;
         sel_cnt_ff  <= '0;
      end else begin
         seen_ff     <= seen_in;
         prev_ovf_ff <= prev_ovf_in;
         sel_cnt_ff  <= sel_cnt_in;
      end
   end

   `ZSCE_ASSERT_ALWAYS(a_idle_after_reset, ($past(reset) |-> !rsp_valid), "result valid right after reset")
   `ZSCE_ASSERT(a_stall_hold, (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_code)), "stalled result changed")
   `ZSCE_ASSERT(a_eoc_count, (taken && rsp_end_of_code |-> rsp_is_selector && (sel_cnt_ff == FW'(SELECTOR_BYTES - 1))), "end of code at wrong selector byte")
   `ZSCE_ASSERT(a_no_low_in_flush, (taken && !rsp_is_selector |-> (sel_cnt_ff == '0)), "low byte inside selector flush")
   `ZSCE_ASSERT(a_flush_ovf, (taken && rsp_is_selector |-> seen_ff && (rsp_overflow == prev_ovf_ff)), "selector overflow differs from last item")

endmodule

bind zero_selector_coeff_encoder zsce_checker #(
   .SELECTOR_BYTES (SELECTOR_BYTES)
) u_zsce_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_is_selector (rsp_is_selector),
   .rsp_overflow    (rsp_overflow),
   .rsp_end_of_code (rsp_end_of_code)
);

`default_nettype wire
